/* rtl/pnm_pkg.sv */
// Shared types and codes for the PNM stream decoder.
// Holds the input item and result structs, result kinds and error codes.
// No dependencies.
package pnm_pkg;

  // One transfer on the input channel.
  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } pnm_item_t;

  // One transfer on the result channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic [1:0]  channels;
    logic        text_format;
    logic [3:0]  error_code;
    logic        last_sample;
  } pnm_result_t;

  // Up to two results produced by one input item, first result first.
  typedef struct packed {
    logic [1:0]  n_res;
    pnm_result_t res0;
    pnm_result_t res1;
  } pnm_step_t;

  // Input commands.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NOT_PNM      = 4'd1;
  localparam logic [3:0] ERR_EOF_HEADER   = 4'd2;
  localparam logic [3:0] ERR_EOF_DATA     = 4'd3;
  localparam logic [3:0] ERR_SIZE         = 4'd4;
  localparam logic [3:0] ERR_MAXVAL       = 4'd5;
  localparam logic [3:0] ERR_BINARY_PBM   = 4'd6;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd7;
  localparam logic [3:0] ERR_PAM          = 4'd8;

  // Image format families.
  localparam logic [1:0] FMT_PBM = 2'd0;
  localparam logic [1:0] FMT_PGM = 2'd1;
  localparam logic [1:0] FMT_PPM = 2'd2;

endpackage

/* rtl/pnm_parse.sv */
// Header parser and sample decoder for the PNM stream decoder.
// Consumes one registered input item per enabled cycle and produces up to two results.
// Depends on pnm_pkg.
module pnm_parse #(
  parameter int DIM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  pnm_pkg::pnm_item_t  item,
  output pnm_pkg::pnm_step_t  step
);
  import pnm_pkg::*;

  // Accumulator holds a full header number plus room for one more digit.
  localparam int ACC_W = ((DIM_BITS > 17) ? DIM_BITS : 17) + 4;
  localparam logic [ACC_W-1:0] DIM_LIMIT    = ACC_W'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] MAXVAL_LIMIT = ACC_W'(17'd65535);
  localparam logic [ACC_W-1:0] TEXT_MASK    = ACC_W'(17'h1ffff);
  localparam logic [15:0]      PBM_MAXVAL   = 16'd255;

  // Character codes.
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef enum logic [3:0] {
    PH_MAGIC1,
    PH_MAGIC2,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_TEXTPRE,
    PH_TEXTDATA,
    PH_BINDATA,
    PH_DONE,
    PH_HALT
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic                in_comment_r, in_comment_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [15:0]         maxval_r, maxval_nxt;
  logic [1:0]          fmt_r, fmt_nxt;
  logic                ascii_r, ascii_nxt;
  logic                wide_r, wide_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [1:0]          chan_r, chan_nxt;
  logic [7:0]          hold_r, hold_nxt;
  logic                parity_r, parity_nxt;

  // Byte classification.
  logic [7:0]       b;
  logic             is_digit;
  logic             is_ws;
  logic [ACC_W-1:0] digit_val;
  logic [ACC_W-1:0] acc_times10;

  assign b           = item.byte_value;
  assign is_digit    = (b >= CH_0) && (b <= CH_9);
  assign is_ws       = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  assign digit_val   = ACC_W'(b - CH_0);
  assign acc_times10 = (acc_r << 3) + (acc_r << 1) + digit_val;

  // Sample position tracking: last-sample flag and the advanced counters.
  logic [1:0]        chans_r;
  logic [DIM_BITS:0] row_p1;
  logic [DIM_BITS:0] col_p1;
  logic [2:0]        chan_p1;
  logic              smp_last;
  logic              chan_wrap;
  logic              col_wrap;

  assign chans_r   = (fmt_r == FMT_PPM) ? 2'd3 : 2'd1;
  assign row_p1    = {1'b0, row_r} + 1'b1;
  assign col_p1    = {1'b0, col_r} + 1'b1;
  assign chan_p1   = {1'b0, chan_r} + 1'b1;
  assign chan_wrap = chan_p1 >= {1'b0, chans_r};
  assign col_wrap  = col_p1 >= {1'b0, width_r};
  assign smp_last  = (row_p1 >= {1'b0, height_r}) && col_wrap && chan_wrap;

  // ASCII sample value from the accumulator.
  logic [15:0] text_masked;
  logic [15:0] text_val;

  assign text_masked = wide_r ? acc_r[15:0] : {8'h00, acc_r[7:0]};
  assign text_val    = (fmt_r == FMT_PBM) ? ((text_masked != 16'd0) ? 16'd0 : maxval_r)
                                          : text_masked;

  // Result requests from the step logic.
  logic        hdr_emit;
  logic        smp_emit;
  logic        err_emit;
  logic [15:0] smp_val;
  logic [3:0]  err_code;

  // Step logic: one input item against the current state.
  always_comb begin
    logic [3:0]       junk;
    logic             cont;
    logic [ACC_W-1:0] limit;
    phase_t           ph;

    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    digit_seen_nxt = digit_seen_r;
    in_comment_nxt = in_comment_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    maxval_nxt     = maxval_r;
    fmt_nxt        = fmt_r;
    ascii_nxt      = ascii_r;
    wide_nxt       = wide_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    chan_nxt       = chan_r;
    hold_nxt       = hold_r;
    parity_nxt     = parity_r;
    hdr_emit       = 1'b0;
    smp_emit       = 1'b0;
    err_emit       = 1'b0;
    smp_val        = 16'd0;
    err_code       = ERR_NONE;
    junk           = (phase_r == PH_MAXVAL) ? ERR_MAXVAL : ERR_SIZE;
    limit          = (phase_r == PH_MAXVAL) ? MAXVAL_LIMIT : DIM_LIMIT;
    cont           = 1'b1;
    ph             = phase_r;

    if (item.command == CMD_EOS) begin
      // End of stream: flush a pending ASCII number, flag what is missing.
      case (phase_r)
        PH_TEXTDATA: begin
          if (digit_seen_r) begin
            smp_emit = 1'b1;
            smp_val  = text_val;
            if (!smp_last) begin
              err_emit = 1'b1;
              err_code = ERR_EOF_DATA;
            end
          end else begin
            err_emit = 1'b1;
            err_code = ERR_EOF_DATA;
          end
        end
        PH_BINDATA: begin
          err_emit = 1'b1;
          err_code = ERR_EOF_DATA;
        end
        PH_DONE, PH_HALT: begin
        end
        default: begin
          err_emit = 1'b1;
          err_code = ERR_EOF_HEADER;
        end
      endcase
      // Every phase returns to the reset state for the next file.
      phase_nxt      = PH_MAGIC1;
      acc_nxt        = '0;
      digit_seen_nxt = 1'b0;
      in_comment_nxt = 1'b0;
      width_nxt      = '0;
      height_nxt     = '0;
      maxval_nxt     = '0;
      fmt_nxt        = FMT_PBM;
      ascii_nxt      = 1'b0;
      wide_nxt       = 1'b0;
      col_nxt        = '0;
      row_nxt        = '0;
      chan_nxt       = '0;
      hold_nxt       = '0;
      parity_nxt     = 1'b0;
    end else begin
      case (phase_r)
        PH_MAGIC1: begin
          if (b == CH_P) begin
            phase_nxt = PH_MAGIC2;
          end else begin
            err_emit  = 1'b1;
            err_code  = ERR_NOT_PNM;
            phase_nxt = PH_HALT;
          end
        end

        PH_MAGIC2: begin
          if (b == CH_7) begin
            err_emit  = 1'b1;
            err_code  = ERR_PAM;
            phase_nxt = PH_HALT;
          end else if ((b < CH_1) || (b > CH_6)) begin
            err_emit  = 1'b1;
            err_code  = ERR_NOT_PNM;
            phase_nxt = PH_HALT;
          end else begin
            ascii_nxt = (b <= CH_3);
            if ((b == CH_1) || (b == CH_4)) begin
              fmt_nxt = FMT_PBM;
            end else if ((b == CH_2) || (b == CH_5)) begin
              fmt_nxt = FMT_PGM;
            end else begin
              fmt_nxt = FMT_PPM;
            end
            acc_nxt        = '0;
            digit_seen_nxt = 1'b0;
            in_comment_nxt = 1'b0;
            phase_nxt      = PH_WIDTH;
          end
        end

        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (in_comment_r) begin
            if (b == CH_LF) begin
              in_comment_nxt = 1'b0;
            end
          end else if (is_digit) begin
            // Accumulate and reject as soon as the limit is passed.
            acc_nxt        = acc_times10;
            digit_seen_nxt = 1'b1;
            if (acc_times10 > limit) begin
              err_emit  = 1'b1;
              err_code  = junk;
              phase_nxt = PH_HALT;
            end
          end else begin
            if (digit_seen_r) begin
              if (acc_r == '0) begin
                err_emit  = 1'b1;
                err_code  = junk;
                phase_nxt = PH_HALT;
                cont      = 1'b0;
              end else begin
                acc_nxt        = '0;
                digit_seen_nxt = 1'b0;
                in_comment_nxt = 1'b0;
                if (phase_r == PH_WIDTH) begin
                  width_nxt = DIM_BITS'(acc_r);
                  ph        = PH_HEIGHT;
                end else if (phase_r == PH_HEIGHT) begin
                  height_nxt = DIM_BITS'(acc_r);
                  if (fmt_r == FMT_PBM) begin
                    maxval_nxt = PBM_MAXVAL;
                    wide_nxt   = 1'b0;
                    cont       = 1'b0;
                  end else begin
                    ph = PH_MAXVAL;
                  end
                end else begin
                  maxval_nxt = acc_r[15:0];
                  wide_nxt   = (acc_r > ACC_W'(PBM_MAXVAL));
                  cont       = 1'b0;
                end

                // Header complete: the ending byte decides what follows.
                if (!cont) begin
                  if (ascii_r) begin
                    if (is_ws) begin
                      ph = PH_TEXTPRE;
                    end else if (b == CH_HASH) begin
                      ph             = PH_TEXTPRE;
                      in_comment_nxt = 1'b1;
                    end else begin
                      hdr_emit = 1'b1;
                      ph       = PH_TEXTDATA;
                    end
                  end else if (!is_ws) begin
                    err_emit = 1'b1;
                    err_code = ERR_UNTERMINATED;
                    ph       = PH_HALT;
                  end else begin
                    hdr_emit = 1'b1;
                    if (fmt_r == FMT_PBM) begin
                      err_emit = 1'b1;
                      err_code = ERR_BINARY_PBM;
                      ph       = PH_HALT;
                    end else begin
                      ph = PH_BINDATA;
                    end
                  end
                end
                phase_nxt = ph;
                junk      = (ph == PH_MAXVAL) ? ERR_MAXVAL : ERR_SIZE;
              end
            end
            if (cont) begin
              if (is_ws) begin
              end else if (b == CH_HASH) begin
                in_comment_nxt = 1'b1;
              end else begin
                err_emit  = 1'b1;
                err_code  = junk;
                phase_nxt = PH_HALT;
              end
            end
          end
        end

        PH_TEXTPRE: begin
          // Skip whitespace and comments before the first ASCII sample.
          if (in_comment_r) begin
            if (b == CH_LF) begin
              in_comment_nxt = 1'b0;
            end
          end else if (is_ws) begin
          end else if (b == CH_HASH) begin
            in_comment_nxt = 1'b1;
          end else begin
            hdr_emit       = 1'b1;
            phase_nxt      = PH_TEXTDATA;
            in_comment_nxt = 1'b0;
            if (is_digit) begin
              acc_nxt        = digit_val;
              digit_seen_nxt = 1'b1;
            end else begin
              acc_nxt        = '0;
              digit_seen_nxt = 1'b0;
            end
          end
        end

        PH_TEXTDATA: begin
          if (is_digit) begin
            acc_nxt        = acc_times10 & TEXT_MASK;
            digit_seen_nxt = 1'b1;
          end else if (digit_seen_r) begin
            smp_emit       = 1'b1;
            smp_val        = text_val;
            acc_nxt        = '0;
            digit_seen_nxt = 1'b0;
          end
        end

        PH_BINDATA: begin
          // Binary samples: one byte, or a big-endian byte pair.
          if (!wide_r) begin
            smp_emit = 1'b1;
            smp_val  = {8'h00, b};
          end else if (!parity_r) begin
            hold_nxt   = b;
            parity_nxt = 1'b1;
          end else begin
            parity_nxt = 1'b0;
            smp_emit   = 1'b1;
            smp_val    = {hold_r, b};
          end
        end

        default: begin
        end
      endcase

      // Sample bookkeeping: stop after the last one, else advance position.
      if (smp_emit) begin
        if (smp_last) begin
          phase_nxt = PH_DONE;
        end else if (chan_wrap) begin
          chan_nxt = '0;
          if (col_wrap) begin
            col_nxt = '0;
            row_nxt = row_p1[DIM_BITS-1:0];
          end else begin
            col_nxt = col_p1[DIM_BITS-1:0];
          end
        end else begin
          chan_nxt = chan_p1[1:0];
        end
      end

      // A header restarts the sample position.
      if (hdr_emit) begin
        col_nxt    = '0;
        row_nxt    = '0;
        chan_nxt   = '0;
        hold_nxt   = '0;
        parity_nxt = 1'b0;
      end
    end
  end

  // Result assembly: header or sample first, then any error.
  always_comb begin
    pnm_result_t hdr_res;
    pnm_result_t smp_res;
    pnm_result_t err_res;

    hdr_res              = '0;
    hdr_res.kind         = KIND_HEADER;
    hdr_res.image_width  = 16'(width_nxt);
    hdr_res.image_height = 16'(height_nxt);
    hdr_res.max_value    = maxval_nxt;
    hdr_res.channels     = (fmt_nxt == FMT_PPM) ? 2'd3 : 2'd1;
    hdr_res.text_format  = ascii_nxt;

    smp_res             = '0;
    smp_res.kind        = KIND_SAMPLE;
    smp_res.sample      = smp_val;
    smp_res.last_sample = smp_last;

    err_res            = '0;
    err_res.kind       = KIND_ERROR;
    err_res.error_code = err_code;

    step = '0;
    if (hdr_emit || smp_emit) begin
      step.res0 = hdr_emit ? hdr_res : smp_res;
      if (err_emit) begin
        step.res1  = err_res;
        step.n_res = 2'd2;
      end else begin
        step.n_res = 2'd1;
      end
    end else if (err_emit) begin
      step.res0  = err_res;
      step.n_res = 2'd1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC1;
      acc_r        <= '0;
      digit_seen_r <= 1'b0;
      in_comment_r <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
      maxval_r     <= '0;
      fmt_r        <= FMT_PBM;
      ascii_r      <= 1'b0;
      wide_r       <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      chan_r       <= '0;
      hold_r       <= '0;
      parity_r     <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      digit_seen_r <= digit_seen_nxt;
      in_comment_r <= in_comment_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      maxval_r     <= maxval_nxt;
      fmt_r        <= fmt_nxt;
      ascii_r      <= ascii_nxt;
      wide_r       <= wide_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      chan_r       <= chan_nxt;
      hold_r       <= hold_nxt;
      parity_r     <= parity_nxt;
    end
  end

endmodule

/* rtl/pnm_res_fifo.sv */
// Result queue for the PNM stream decoder.
// Takes up to two results per cycle from the parser and presents one per transfer.
// Depends on pnm_pkg.
module pnm_res_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  pnm_pkg::pnm_step_t   step,
  output logic                 space_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pnm_pkg::pnm_result_t out_data
);
  import pnm_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  pnm_result_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       n_push;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  // Room for the largest burst one item can produce.
  assign space_ok  = count_r <= CNT_W'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign n_push    = push_en ? step.n_res : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_r] <= step.res0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_p1] <= step.res1;
    end
  end

endmodule

/* rtl/pnm_stream_decoder_top.sv */
// PNM stream decoder: takes a PNM file one byte per transfer and emits header,
// sample and error results. Depends on pnm_pkg, pnm_parse and pnm_res_fifo.
//
// Input channel (in_valid, in_stall, in_data): one byte or an end-of-stream
// command per transfer. Result channel (out_valid, out_stall, out_data): one
// header, sample or error result per transfer.
// An accepted item is held in the input register, is decoded, and its results
// enter a four-entry result queue, which offers them in order. One input
// item is accepted every cycle as long as results drain; the parser advances
// when the queue has room for two.
// Most items give zero or one result; a header followed by an error, or a
// final ASCII sample followed by an end-of-data error, gives two.
// While the receiver stalls, results wait in the queue and in_stall rises once
// the queue cannot take another item's worth of results.
// Reset puts the parser in the state that expects the first magic byte and
// empties the queue. An end-of-stream command also returns the parser to that
// state, ready for the next file.
module pnm_stream_decoder_top #(
  parameter int DIM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pnm_pkg::pnm_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pnm_pkg::pnm_result_t out_data
);
  import pnm_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  pnm_item_t  in_item_r;
  logic       space_ok;
  logic       step_en;
  logic       in_take;
  pnm_step_t  step;

  // The held item moves into the parser when the queue has room.
  assign step_en  = in_vld_r && space_ok;
  assign in_stall = in_vld_r && !space_ok;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  pnm_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .step    (step)
  );

  pnm_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (step_en),
    .step      (step),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/pnm_stream_decoder_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pnm_stream_decoder_top: feeds PNM files byte by byte
// and checks every header, sample and error result against a built-in decoder.
// Depends on pnm_pkg and the RTL of pnm_stream_decoder_top.
module pnm_stream_decoder_top_tb;
  import pnm_pkg::*;

  localparam int DIM_BITS = 16;
  localparam longint unsigned DIM_LIMIT = (64'd1 << DIM_BITS) - 64'd1;
  localparam int ITEM_TARGET = 1450;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int DATA_CAP = 40;

  // Decoder states of the expected-result predictor.
  typedef enum logic [3:0] {
    ST_MAGIC1, ST_MAGIC2, ST_WIDTH, ST_HEIGHT, ST_MAXVAL,
    ST_TEXT_PRE, ST_TEXT_DATA, ST_BIN_DATA, ST_DONE, ST_HALT
  } dec_state_t;

  // Tracks the decoder state, predicts the results of each transfer and checks them.
  class pnm_decode_checker;
    dec_state_t st;
    longint unsigned acc;
    bit digit_seen, in_comment;
    int unsigned width, height, maxval;
    logic [1:0] fmt;
    bit ascii, wide;
    int unsigned col, row, chan;
    logic [7:0] hi_byte;
    bit hi_pending;
    int unsigned step_count;
    pnm_result_t pending_results[$];
    int unsigned items_decoded;
    int unsigned fail_count;

    function void clear_number();
      acc = 0;
      digit_seen = 0;
      in_comment = 0;
    endfunction

    function void clear_state();
      st = ST_MAGIC1;
      clear_number();
      width = 0;
      height = 0;
      maxval = 0;
      fmt = FMT_PBM;
      ascii = 0;
      wide = 0;
      col = 0;
      row = 0;
      chan = 0;
      hi_byte = '0;
      hi_pending = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void push_result(logic [1:0] kind, int unsigned smp, int unsigned w,
                              int unsigned h, int unsigned m, int unsigned ch,
                              bit txt, logic [3:0] err, bit last);
      pnm_result_t r;
      if (step_count >= 2) return;
      r.kind = kind;
      r.sample = smp[15:0];
      r.image_width = w[15:0];
      r.image_height = h[15:0];
      r.max_value = m[15:0];
      r.channels = ch[1:0];
      r.text_format = txt;
      r.error_code = err;
      r.last_sample = last;
      pending_results.push_back(r);
      step_count++;
    endfunction

    function void flag_error(logic [3:0] err);
      push_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, err, 0);
      st = ST_HALT;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == " " || (b >= "\t" && b <= "\r");
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function int unsigned chan_total();
      return (fmt == FMT_PPM) ? 3 : 1;
    endfunction

    function void emit_header();
      push_result(KIND_HEADER, 0, width, height, maxval, chan_total(), ascii, ERR_NONE, 0);
      col = 0;
      row = 0;
      chan = 0;
      hi_byte = '0;
      hi_pending = 0;
    endfunction

    // One sample; the last one of the image closes the file.
    function void emit_sample(int unsigned v);
      int unsigned nch;
      bit last;
      nch = chan_total();
      last = (row + 1 >= height) && (col + 1 >= width) && (chan + 1 >= nch);
      push_result(KIND_SAMPLE, v, 0, 0, 0, 0, 0, ERR_NONE, last);
      if (last) begin
        st = ST_DONE;
        return;
      end
      chan++;
      if (chan >= nch) begin
        chan = 0;
        col++;
        if (col >= width) begin
          col = 0;
          row++;
        end
      end
    endfunction

    // A finished ASCII number, masked; bitmap values are inverted.
    function void text_sample();
      int unsigned v;
      v = 32'(acc & (wide ? 64'hffff : 64'hff));
      if (fmt == FMT_PBM) v = (v != 0) ? 0 : maxval;
      acc = 0;
      digit_seen = 0;
      emit_sample(v);
    endfunction

    function void text_byte(logic [7:0] b);
      if (is_digit(b)) begin
        acc = (acc * 10 + (b - "0")) & 64'h1ffff;
        digit_seen = 1;
      end else if (digit_seen) begin
        text_sample();
      end
    endfunction

    // Between the ASCII header and the first sample: blanks and comments are skipped.
    function void pre_data_byte(logic [7:0] b);
      if (in_comment) begin
        if (b == "\n") in_comment = 0;
        return;
      end
      if (is_blank(b)) return;
      if (b == "#") begin
        in_comment = 1;
        return;
      end
      emit_header();
      clear_number();
      st = ST_TEXT_DATA;
      text_byte(b);
    endfunction

    function void finish_header(logic [7:0] b);
      clear_number();
      if (ascii) begin
        st = ST_TEXT_PRE;
        pre_data_byte(b);
        return;
      end
      if (!is_blank(b)) begin
        flag_error(ERR_UNTERMINATED);
        return;
      end
      emit_header();
      if (fmt == FMT_PBM) begin
        flag_error(ERR_BINARY_PBM);
        return;
      end
      st = ST_BIN_DATA;
    endfunction

    // Width, height and maxval fields with blanks and comments between them.
    function void header_byte(logic [7:0] b);
      logic [3:0] junk_err;
      longint unsigned lim;
      int unsigned v;
      junk_err = (st == ST_MAXVAL) ? ERR_MAXVAL : ERR_SIZE;
      if (in_comment) begin
        if (b == "\n") in_comment = 0;
        return;
      end
      if (is_digit(b)) begin
        acc = acc * 10 + (b - "0");
        digit_seen = 1;
        lim = (st == ST_MAXVAL) ? 64'd65535 : DIM_LIMIT;
        if (acc > lim) flag_error(junk_err);
        return;
      end
      if (digit_seen) begin
        v = 32'(acc);
        if (v == 0) begin
          flag_error(junk_err);
          return;
        end
        clear_number();
        if (st == ST_WIDTH) begin
          width = v;
          st = ST_HEIGHT;
        end else if (st == ST_HEIGHT) begin
          height = v;
          if (fmt == FMT_PBM) begin
            maxval = 255;
            wide = 0;
            finish_header(b);
            return;
          end
          st = ST_MAXVAL;
        end else begin
          maxval = v;
          wide = (v > 255);
          finish_header(b);
          return;
        end
        junk_err = (st == ST_MAXVAL) ? ERR_MAXVAL : ERR_SIZE;
      end
      if (is_blank(b)) return;
      if (b == "#") begin
        in_comment = 1;
        return;
      end
      flag_error(junk_err);
    endfunction

    // Notes one input transfer and queues the results it must cause.
    function void accept_item(pnm_item_t item);
      logic [7:0] b;
      b = item.byte_value;
      step_count = 0;
      items_decoded++;
      if (item.command == CMD_EOS) begin
        case (st)
          ST_TEXT_DATA: begin
            if (digit_seen) text_sample();
            if (st != ST_DONE) flag_error(ERR_EOF_DATA);
          end
          ST_BIN_DATA: flag_error(ERR_EOF_DATA);
          ST_DONE, ST_HALT: ;
          default: flag_error(ERR_EOF_HEADER);
        endcase
        clear_state();
        return;
      end
      case (st)
        ST_MAGIC1: begin
          if (b == "P") st = ST_MAGIC2;
          else flag_error(ERR_NOT_PNM);
        end
        ST_MAGIC2: begin
          if (b == "7") begin
            flag_error(ERR_PAM);
          end else if (b < "1" || b > "6") begin
            flag_error(ERR_NOT_PNM);
          end else begin
            ascii = (b <= "3");
            case (b)
              "1", "4": fmt = FMT_PBM;
              "2", "5": fmt = FMT_PGM;
              default: fmt = FMT_PPM;
            endcase
            clear_number();
            st = ST_WIDTH;
          end
        end
        ST_WIDTH, ST_HEIGHT, ST_MAXVAL: header_byte(b);
        ST_TEXT_PRE: pre_data_byte(b);
        ST_TEXT_DATA: text_byte(b);
        ST_BIN_DATA: begin
          if (!wide) begin
            emit_sample(32'(b));
          end else if (!hi_pending) begin
            hi_byte = b;
            hi_pending = 1;
          end else begin
            hi_pending = 0;
            emit_sample(32'({hi_byte, b}));
          end
        end
        default: ;
      endcase
    endfunction

    function string show(pnm_result_t r);
      return $sformatf("{kind=%0d smp=%h w=%0d h=%0d max=%0d ch=%0d txt=%0d err=%0d last=%0d}",
                       r.kind, r.sample, r.image_width, r.image_height, r.max_value,
                       r.channels, r.text_format, r.error_code, r.last_sample);
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // Compares one result transfer with the oldest pending result.
    function void check_result(pnm_result_t got);
      pnm_result_t want;
      string bad;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %s", show(got)));
        return;
      end
      want = pending_results.pop_front();
      bad = "";
      if (got.kind !== want.kind) bad = {bad, " kind"};
      if (got.sample !== want.sample) bad = {bad, " sample"};
      if (got.image_width !== want.image_width) bad = {bad, " image_width"};
      if (got.image_height !== want.image_height) bad = {bad, " image_height"};
      if (got.max_value !== want.max_value) bad = {bad, " max_value"};
      if (got.channels !== want.channels) bad = {bad, " channels"};
      if (got.text_format !== want.text_format) bad = {bad, " text_format"};
      if (got.error_code !== want.error_code) bad = {bad, " error_code"};
      if (got.last_sample !== want.last_sample) bad = {bad, " last_sample"};
      if (bad != "") begin
        note_failure($sformatf("mismatch in%s: expected %s, got %s", bad, show(want), show(got)));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pnm_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pnm_result_t out_data;

  pnm_decode_checker board;
  pnm_item_t file_q[$];
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int unsigned cycles = 0;

  pnm_stream_decoder_top #(.DIM_BITS(DIM_BITS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("pnm_stream_decoder_top_tb NOT OK");
      $finish;
    end
  end

  // Receiver stall pattern: free, light, heavy or solid stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // Every result transfer is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  function automatic void add_byte(logic [7:0] b);
    pnm_item_t it;
    it.command = CMD_DATA;
    it.byte_value = b;
    file_q.push_back(it);
  endfunction

  function automatic void add_eos();
    pnm_item_t it;
    it.command = CMD_EOS;
    it.byte_value = $urandom_range(0, 255);
    file_q.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_number(int unsigned v);
    if ($urandom_range(0, 9) == 0) add_byte("0");
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_blank();
    int idx;
    idx = $urandom_range(0, 5);
    add_byte((idx == 5) ? 8'd32 : 8'(8'd9 + idx));
  endfunction

  // Header separator: blanks, comments and now and then a stray byte.
  function automatic void add_gap();
    int n;
    int r;
    n = $urandom_range(1, 3);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        add_byte("#");
        repeat ($urandom_range(0, 6)) add_byte($urandom_range(11, 255));
        add_byte("\n");
      end else if (r < 23) begin
        add_byte($urandom_range(0, 255));
      end else begin
        add_blank();
      end
    end
  endfunction

  function automatic int unsigned pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 4);
    if (r < 87) return $urandom_range(5, 16);
    if (r < 91) return 65535;
    if (r < 95) return 0;
    return $urandom_range(65536, 999999);
  endfunction

  // Builds one file: mostly well-formed with random content, some broken or pure noise.
  function automatic void build_file();
    int unsigned digit, w, h, mv, v, nch, n;
    longint unsigned total;
    bit asc, pbm, wd, cut;
    int r;
    logic [7:0] sep;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(3, 15)) begin
        if ($urandom_range(0, 9) == 0) add_eos();
        else add_byte($urandom_range(0, 255));
      end
      add_eos();
      return;
    end
    digit = $urandom_range(1, 6);
    if (digit == 4 && $urandom_range(0, 2) != 0) digit = 6;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      add_byte($urandom_range(0, 255));
      add_byte("0" + digit);
    end else if (r < 8) begin
      add_text("P7");
    end else if (r < 11) begin
      add_byte("P");
      add_byte($urandom_range(0, 255));
    end else begin
      add_byte("P");
      add_byte("0" + digit);
    end
    asc = (digit <= 3);
    pbm = (digit == 1 || digit == 4);
    nch = (digit == 3 || digit == 6) ? 3 : 1;

    // Header numbers; a number may follow the magic directly.
    if ($urandom_range(0, 3) != 0) add_gap();
    w = pick_dim();
    add_number(w);
    add_gap();
    h = pick_dim();
    add_number(h);
    mv = 255;
    if (!pbm) begin
      add_gap();
      r = $urandom_range(0, 99);
      if (r < 30) mv = 255;
      else if (r < 50) mv = $urandom_range(1, 254);
      else if (r < 60) mv = 1;
      else if (r < 70) mv = $urandom_range(257, 65534);
      else if (r < 80) mv = 65535;
      else if (r < 86) mv = 256;
      else if (r < 92) mv = 0;
      else mv = $urandom_range(65536, 999999);
      add_number(mv);
    end

    // Header terminator; binary files need exactly one blank.
    if (asc) begin
      if ($urandom_range(0, 7) == 0) add_byte($urandom_range(0, 255));
      else add_gap();
    end else begin
      if ($urandom_range(0, 11) == 0) add_byte($urandom_range(0, 255));
      else add_blank();
    end

    // Pixel data, cut short for huge images and now and then on purpose.
    wd = (mv > 255);
    total = longint'(w) * h * nch;
    n = (total > DATA_CAP) ? DATA_CAP : 32'(total);
    cut = 0;
    if (n > 0 && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(0, n - 1);
      cut = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (!asc) begin
        add_byte($urandom_range(0, 255));
        if (wd) add_byte($urandom_range(0, 255));
      end else begin
        r = $urandom_range(0, 99);
        if (pbm) v = (r < 80) ? $urandom_range(0, 1) : $urandom_range(0, 20);
        else v = (r < 85) ? $urandom_range(0, mv) : $urandom_range(0, 999999);
        add_number(v);
        if (i == n - 1 && $urandom_range(0, 2) == 0) continue;
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 9) < 7) begin
            add_blank();
          end else begin
            sep = $urandom_range(0, 245);
            if (sep >= "0") sep = sep + 8'd10;
            add_byte(sep);
          end
        end
      end
    end
    if (cut && wd && !asc && $urandom_range(0, 1) == 0) add_byte($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) add_byte($urandom_range(0, 255));
    if (file_q.size() > 0 && $urandom_range(0, 19) == 0) begin
      file_q[$urandom_range(0, file_q.size() - 1)].byte_value = $urandom_range(0, 255);
    end
    add_eos();
  endfunction

  // Sends the queued items in bursts with random gaps between them.
  task automatic send_all();
    pnm_item_t it;
    int gap;
    while (file_q.size() != 0) begin
      it = file_q.pop_front();
      if (burst_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(50, 100);
          gap = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid <= 1'b1;
      in_data <= it;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.accept_item(it);
    end
  endtask

  // Holds the sender off until every pending result has been transferred.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    board = new;
    board.clear_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files: end of stream after reset, non-PNM bytes, PAM magic,
    // binary bitmap, and an ASCII bitmap whose only sample ends at end of stream.
    add_eos();
    add_byte(8'h00);
    add_byte(8'hff);
    add_eos();
    add_text("P7");
    add_eos();
    add_text("P4 1 1\n");
    add_eos();
    add_text("P1 1 1 0");
    add_eos();
    send_all();
    wait_results();

    // Random files.
    while (board.items_decoded < ITEM_TARGET) begin
      build_file();
      send_all();
      if ($urandom_range(0, 9) == 0) wait_results();
    end
    wait_results();
    repeat (12) @(negedge clk);

    if (board.pending() != 0) board.note_failure("results never transferred");
    if (board.fail_count == 0) begin
      $display("pnm_stream_decoder_top_tb OK");
    end else begin
      $display("pnm_stream_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
